@@ rtl/cjt_pkg.sv @@
// Shared types and constants for the cron job table matcher.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cjt_pkg;

    // Default number of job slots
    localparam int JOBS_DEF = 8;

    // Field widths
    localparam int OP_W     = 1;
    localparam int JIDX_W   = 3;
    localparam int WSEL_W   = 3;
    localparam int DATA_W   = 60;
    localparam int MINUTE_W = 6;
    localparam int HOUR_W   = 5;
    localparam int DOM_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int WDAY_W   = 3;
    localparam int SECOND_W = 6;
    localparam int STAMP_W  = 32;
    localparam int WINDOW_W = 6;
    localparam int ACTION_W = 2;
    localparam int PIN_W    = 5;

    // Per-job set widths
    localparam int MIN_SET_W  = 60;
    localparam int HOUR_SET_W = 24;
    localparam int DAY_SET_W  = 31;
    localparam int MON_SET_W  = 12;
    localparam int WDAY_SET_W = 7;
    localparam int CTL_W      = 9;

    localparam logic [WINDOW_W-1:0] RUN_WINDOW_RST = 6'd5;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OP_W-1:0] OP_TICK  = 1'b1;

    // Word selects
    localparam logic [WSEL_W-1:0] WS_MINUTE   = 3'd0;
    localparam logic [WSEL_W-1:0] WS_HOUR     = 3'd1;
    localparam logic [WSEL_W-1:0] WS_DAY      = 3'd2;
    localparam logic [WSEL_W-1:0] WS_MONTH    = 3'd3;
    localparam logic [WSEL_W-1:0] WS_WEEKDAY  = 3'd4;
    localparam logic [WSEL_W-1:0] WS_CONTROL  = 3'd5;
    localparam logic [WSEL_W-1:0] WS_LAST_RUN = 3'd6;

    // Control word layout
    localparam int CTL_ACTIVE_BIT = 0;
    localparam int CTL_ACTION_LSB = 1;
    localparam int CTL_PIN_LSB    = 3;
    localparam int CTL_VALUE_BIT  = 8;

    // Tick record travelling down the cell chain
    typedef struct packed {
        logic                valid;
        logic                en;       // second within window
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DOM_W-1:0]    dom;
        logic [MONTH_W-1:0]  month;
        logic [WDAY_W-1:0]   wday;
        logic [STAMP_W-1:0]  epoch;
    } t_tick;

    // Job word write broadcast
    typedef struct packed {
        logic              we;
        logic [WSEL_W-1:0] sel;
        logic [DATA_W-1:0] data;
    } t_jwr;

    // Action fields of a job
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PIN_W-1:0]    pin;
        logic                value;
    } t_act;

endpackage

`default_nettype wire

@@ rtl/cjt_in_if.sv @@
// Input item channel: valid/ready plus the item fields.
// Depends on cjt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cjt_in_if
    import cjt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [JIDX_W-1:0]   job_index;
    logic [WSEL_W-1:0]   word_select;
    logic [DATA_W-1:0]   write_data;
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
    logic [DOM_W-1:0]    day_of_month;
    logic [MONTH_W-1:0]  month;
    logic [WDAY_W-1:0]   weekday;
    logic [SECOND_W-1:0] second;
    logic [STAMP_W-1:0]  epoch_seconds;

    modport source (
        output valid, op, job_index, word_select, write_data, minute, hour,
               day_of_month, month, weekday, second, epoch_seconds,
        input  ready
    );
    modport sink (
        input  valid, op, job_index, word_select, write_data, minute, hour,
               day_of_month, month, weekday, second, epoch_seconds,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/cjt_out_if.sv @@
// Result channel: valid/ready plus the result fields.
// Depends on cjt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cjt_out_if
    import cjt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [JIDX_W-1:0]   fired_job;
    logic [ACTION_W-1:0] action;
    logic [PIN_W-1:0]    pin;
    logic                pin_value;
    logic                last_of_run;

    modport source (
        output valid, fired_job, action, pin, pin_value, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, fired_job, action, pin, pin_value, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/cjt_cfg_if.sv @@
// Configuration write channel for the run window register.
// Depends on cjt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cjt_cfg_if
    import cjt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WINDOW_W-1:0] run_window;

    modport source (output valid, run_window, input ready);
    modport sink   (input valid, run_window, output ready);
endinterface

`default_nettype wire

@@ rtl/cron_job_table_matcher.sv @@
// Top level of the cron job table matcher: chain of job cells plus sequencer.
// Depends on cjt_pkg, cjt_in_if, cjt_out_if, cjt_cfg_if and cjt_cell.
//
//  channel  | dir | modport | payload
//  ---------+-----+---------+---------------------------------------------
//  i_in     | in  | sink    | op, job_index, word_select, write_data, time
//  o_out    | out | source  | fired_job, action, pin, pin_value, last_of_run
//  i_cfg    | in  | sink    | run_window (always ready)
//
// A write item leaves the sequencer idle, so the input stays ready.
// A tick walks the cell chain one cell per cycle, then the fired jobs move into
// the output register one per cycle while the output is not stalled, and the
// sequencer then returns to idle.
// Output stalls hold the emit phase; the input stays closed until all results
// of a tick are in the output register. Reset (sync, active low) clears all
// job words to zero, run_window to 5 and drops o_out.valid.
`timescale 1ns / 1ps
`default_nettype none

module cron_job_table_matcher
    import cjt_pkg::*;
#(
    parameter int JOBS = JOBS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    cjt_in_if.sink   i_in,
    cjt_out_if.source o_out,
    cjt_cfg_if.sink  i_cfg
);

    localparam int IW = (JOBS > 1) ? $clog2(JOBS) : 1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [WINDOW_W-1:0] r_window;
    t_tick               r_tk, n_tk;
    t_jwr                wr;

    t_tick               tk   [0:JOBS];
    t_act                acts [0:JOBS-1];
    logic [JOBS-1:0]     fire;
    logic [JOBS-1:0]     low;
    logic [JOBS-1:0]     clr;
    logic [JOBS-1:0]     we;

    logic                in_xfer, out_load;
    logic [IW-1:0]       sel_idx;
    t_act                sel_act;

    logic                r_out_valid, n_out_valid;
    logic [JIDX_W-1:0]   r_out_job;
    t_act                r_out_act;
    logic                r_out_last;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;

    // Write broadcast; a cell takes it only when its slot is addressed
    assign wr.we   = in_xfer && (i_in.op == OP_WRITE);
    assign wr.sel  = i_in.word_select;
    assign wr.data = i_in.write_data;

    // Tick record, launched into the chain for one cycle
    always_comb begin
        n_tk        = r_tk;
        n_tk.valid  = in_xfer && (i_in.op == OP_TICK);
        if (n_tk.valid) begin
            n_tk.en     = (i_in.second <= SECOND_W'(r_window));
            n_tk.minute = i_in.minute;
            n_tk.hour   = i_in.hour;
            n_tk.dom    = i_in.day_of_month;
            n_tk.month  = i_in.month;
            n_tk.wday   = i_in.weekday;
            n_tk.epoch  = i_in.epoch_seconds;
        end
    end

    assign tk[0] = r_tk;

    for (genvar g = 0; g < JOBS; g++) begin : g_cell
        assign we[g] = wr.we && (32'(i_in.job_index) == 32'(g));

        cjt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_run_window (r_window),
            .i_tk         (tk[g]),
            .o_tk         (tk[g+1]),
            .i_wr         ('{we: we[g], sel: wr.sel, data: wr.data}),
            .i_clr        (clr[g]),
            .o_fire       (fire[g]),
            .o_act        (acts[g])
        );
    end

    // Lowest pending fired job goes out next
    assign low = fire & (~fire + JOBS'(1));

    always_comb begin
        sel_idx = '0;
        sel_act = '0;
        for (int j = 0; j < JOBS; j++) begin
            if (low[j]) begin
                sel_idx = sel_idx | IW'(j);
                sel_act = sel_act | acts[j];
            end
        end
    end

    assign out_load = (r_state == ST_EMIT) && (fire != '0)
                   && (!r_out_valid || o_out.ready);
    assign clr      = out_load ? low : '0;

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (n_tk.valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tk[JOBS].valid) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (fire == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= RUN_WINDOW_RST;
            r_tk        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tk        <= n_tk;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_window <= i_cfg.run_window;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_job  <= JIDX_W'(sel_idx);
            r_out_act  <= sel_act;
            r_out_last <= ((fire & ~low) == '0);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.fired_job   = r_out_job;
    assign o_out.action      = r_out_act.action;
    assign o_out.pin         = r_out_act.pin;
    assign o_out.pin_value   = r_out_act.value;
    assign o_out.last_of_run = r_out_last;

endmodule

`default_nettype wire

@@ rtl/cjt_cell.sv @@
// One job slot of the matcher chain: job state, match logic, tick forward.
// Depends on cjt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cjt_cell
    import cjt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [WINDOW_W-1:0] i_run_window,
    input  wire t_tick               i_tk,
    output      t_tick               o_tk,
    input  wire t_jwr                i_wr,
    input  wire logic                i_clr,
    output      logic                o_fire,
    output      t_act                o_act
);

    logic [MIN_SET_W-1:0]  r_min;
    logic [HOUR_SET_W-1:0] r_hour;
    logic [DAY_SET_W-1:0]  r_day;
    logic [MON_SET_W-1:0]  r_mon;
    logic [WDAY_SET_W-1:0] r_wday;
    logic [CTL_W-1:0]      r_ctl;
    logic [STAMP_W-1:0]    r_last;
    logic                  r_fire;
    t_tick                 r_tk;

    logic                  hit_min, hit_hour, hit_day, hit_mon, hit_wday;
    logic [STAMP_W-1:0]    since;
    logic                  match;

    // Shifts past the set width read as zero: out-of-range values miss.
    assign hit_min  = |(r_min  & (MIN_SET_W'(1)  << i_tk.minute));
    assign hit_hour = |(r_hour & (HOUR_SET_W'(1) << i_tk.hour));
    assign hit_day  = (i_tk.dom != '0)
                    && |(r_day & (DAY_SET_W'(1) << (i_tk.dom - DOM_W'(1))));
    assign hit_mon  = (i_tk.month != '0)
                    && |(r_mon & (MON_SET_W'(1) << (i_tk.month - MONTH_W'(1))));
    assign hit_wday = |(r_wday & (WDAY_SET_W'(1) << i_tk.wday));

    assign since = i_tk.epoch - r_last;
    assign match = i_tk.en && r_ctl[CTL_ACTIVE_BIT]
                && hit_min && hit_hour && hit_day && hit_mon && hit_wday
                && (since > STAMP_W'(i_run_window));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '0;
            r_hour <= '0;
            r_day  <= '0;
            r_mon  <= '0;
            r_wday <= '0;
            r_ctl  <= '0;
            r_last <= '0;
            r_fire <= 1'b0;
            r_tk   <= '0;
        end else begin
            r_tk <= i_tk;
            if (i_tk.valid) begin
                r_fire <= match;
                if (match) begin
                    r_last <= i_tk.epoch;
                end
            end else if (i_clr) begin
                r_fire <= 1'b0;
            end
            if (i_wr.we) begin
                unique case (i_wr.sel)
                    WS_MINUTE:   r_min  <= i_wr.data[MIN_SET_W-1:0];
                    WS_HOUR:     r_hour <= i_wr.data[HOUR_SET_W-1:0];
                    WS_DAY:      r_day  <= i_wr.data[DAY_SET_W-1:0];
                    WS_MONTH:    r_mon  <= i_wr.data[MON_SET_W-1:0];
                    WS_WEEKDAY:  r_wday <= i_wr.data[WDAY_SET_W-1:0];
                    WS_CONTROL:  r_ctl  <= i_wr.data[CTL_W-1:0];
                    WS_LAST_RUN: r_last <= i_wr.data[STAMP_W-1:0];
                    default: ;   // unused select
                endcase
            end
        end
    end

    assign o_tk         = r_tk;
    assign o_fire       = r_fire;
    assign o_act.action = r_ctl[CTL_ACTION_LSB +: ACTION_W];
    assign o_act.pin    = r_ctl[CTL_PIN_LSB +: PIN_W];
    assign o_act.value  = r_ctl[CTL_VALUE_BIT];

endmodule

`default_nettype wire

@@ rtl/cjt_checker.sv @@
// Port-level checks for the cron job table matcher, bound to the top level.
// Depends on cjt_pkg and cron_job_table_matcher.
`timescale 1ns / 1ps
`default_nettype none

module cjt_checker
    import cjt_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic [OP_W-1:0]     i_in_op,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [JIDX_W-1:0]   i_out_job,
    input wire logic                i_out_last
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_job))
        else $error("result dropped or changed under stall");

    // A tick closes the input for its scan
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == OP_TICK) |=> !i_in_ready)
        else $error("input open right after tick transfer");

    // A write leaves the input open
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == OP_WRITE) |=> i_in_ready)
        else $error("input closed after write transfer");

    // More results of the tick still to come: input stays closed
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input open mid run");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind cron_job_table_matcher cjt_checker u_cjt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_job   (o_out.fired_job),
    .i_out_last  (o_out.last_of_run)
);

`default_nettype wire
